@@ hdl/fxalu_pkg.sv @@
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared types and constants for the signed Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

  localparam int FRAC_BITS       = 8;
  localparam int DATA_W          = 32;
  localparam int CMD_W           = 4;
  localparam int ST_W            = 2;
  localparam int NUM_W           = DATA_W + FRAC_BITS;
  localparam int PROD_W          = 2 * DATA_W;
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES      = (NUM_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  localparam int S_TDATA_W   = ((2 * DATA_W + 7) / 8) * 8;
  localparam int M_FIELDS_W  = DATA_W + 1 + ST_W;
  localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
  localparam int M_CMP_BIT   = DATA_W;
  localparam int M_ST_LSB    = DATA_W + 1;

  localparam logic [DATA_W-1:0] S_MAX  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] S_MIN  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] HALF   = PROD_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV,
    CMD_LT, CMD_GT, CMD_LE, CMD_GE,
    CMD_EQ, CMD_NE, CMD_MIN, CMD_MAX,
    CMD_INC, CMD_DEC, CMD_FROM_INT, CMD_TO_INT
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } status_e;

  typedef struct packed {
    status_e           st;
    logic [DATA_W-1:0] val;
  } res_t;

  // divider pipeline stage
  typedef struct packed {
    cmd_e              cmd;
    logic              neg;
    logic              bz;
    logic [DATA_W-1:0] val;
    logic              cmp;
    status_e           st;
    logic [NUM_W-1:0]  num;
    logic [DATA_W-1:0] dvs;
    logic [DATA_W-1:0] rem;
    logic [NUM_W-1:0]  quo;
  } div_t;

  // product / rounding stage
  typedef struct packed {
    cmd_e              cmd;
    logic              neg;
    logic              bz;
    logic [DATA_W-1:0] val;
    logic              cmp;
    status_e           st;
    logic [PROD_W-1:0] wide;
    logic              rup;
  } fin_t;

endpackage

@@ hdl/fixed_point_q24_8_alu.sv @@
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu
// Pipelined signed Q24.8 ALU: add/sub/mul/div, compares, min/max, inc/dec
// and integer conversions, saturating on overflow.
// ----------------------------------------------------------------------------
// Path from input transfer to output valid: radix-2 divider stages,
//   two quotient bits per stage over 40 bits, then product and rounding.
// Throughput: one transfer per cycle while s_axis_tready is high; every command uses the same pipeline.
// Output register plus skid register; s_axis_tready is registered.
// Reset clears only the valid flags; data registers are not reset.
module fixed_point_q24_8_alu (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [fxalu_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // [31:0] operand_a, [63:32] operand_b
  input  logic [fxalu_pkg::CMD_W-1:0]          s_axis_tuser,  // [3:0] command
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [fxalu_pkg::M_TDATA_W-1:0]      m_axis_tdata   // [31:0] value, [32] compare_true,
                                                              // [34:33] status
);

  localparam int DW = fxalu_pkg::DATA_W;
  localparam int NW = fxalu_pkg::NUM_W;
  localparam int FB = fxalu_pkg::FRAC_BITS;
  localparam int SP = fxalu_pkg::STEPS_PER_STAGE;
  localparam int DS = fxalu_pkg::DIV_STAGES;

  function automatic fxalu_pkg::res_t clamp33(input logic [DW:0] s);
    fxalu_pkg::res_t r;
    r.st  = fxalu_pkg::ST_OK;
    r.val = s[DW-1:0];
    if (s[DW] != s[DW-1]) begin
      r.st  = fxalu_pkg::ST_SAT;
      r.val = s[DW] ? fxalu_pkg::S_MIN : fxalu_pkg::S_MAX;
    end
    return r;
  endfunction

  function automatic fxalu_pkg::res_t sat_mag(input logic neg,
                                              input logic [fxalu_pkg::PROD_W-1:0] m);
    fxalu_pkg::res_t r;
    r.st  = fxalu_pkg::ST_OK;
    r.val = m[DW-1:0];
    if (neg) begin
      if (m > fxalu_pkg::PROD_W'(fxalu_pkg::S_MIN)) begin
        r.st  = fxalu_pkg::ST_SAT;
        r.val = fxalu_pkg::S_MIN;
      end else begin
        r.val = DW'(0) - m[DW-1:0];
      end
    end else if (m > fxalu_pkg::PROD_W'(fxalu_pkg::S_MAX)) begin
      r.st  = fxalu_pkg::ST_SAT;
      r.val = fxalu_pkg::S_MAX;
    end
    return r;
  endfunction

  // one restoring divide step: shift in a numerator bit, trial subtract
  function automatic fxalu_pkg::div_t div_step(input fxalu_pkg::div_t s);
    fxalu_pkg::div_t r;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            qbit;
    r     = s;
    trial = {s.rem, s.num[NW-1]};
    diff  = trial - {1'b0, s.dvs};
    qbit  = ~diff[DW];
    r.num = {s.num[NW-2:0], 1'b0};
    r.rem = qbit ? diff[DW-1:0] : trial[DW-1:0];
    r.quo = {s.quo[NW-2:0], qbit};
    return r;
  endfunction

  function automatic fxalu_pkg::div_t div_stage(input fxalu_pkg::div_t s, input int base);
    fxalu_pkg::div_t r;
    r = s;
    for (int j = 0; j < SP; j++) begin
      if ((base * SP + j < NW) && (s.cmd == fxalu_pkg::CMD_DIV)) begin
        r = div_step(r);
      end
    end
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // Pipeline control
  // -------------------------------------------------------------------------
  logic          adv;
  logic          skid_v_q;
  logic          out_v_q;
  logic [DS:0]   vld_q;
  logic          p_v_q;

  assign adv           = ~skid_v_q;
  assign s_axis_tready = adv;

  // -------------------------------------------------------------------------
  // Input decode and combinational operations
  // -------------------------------------------------------------------------
  logic signed [DW-1:0] a_s, b_s;
  fxalu_pkg::cmd_e      cmd;
  fxalu_pkg::div_t      init_s;
  logic [DW:0]          sum_s, dif_s, inc_s, dec_s;
  logic [DW-1:0]        ma, mb;
  logic                 lt, gt, eq;
  logic [FB:0]          fi_top;
  fxalu_pkg::res_t      simple;

  assign a_s = s_axis_tdata[DW-1:0];
  assign b_s = s_axis_tdata[2*DW-1:DW];
  assign cmd = fxalu_pkg::cmd_e'(s_axis_tuser);

  always_comb begin
    sum_s  = {a_s[DW-1], a_s} + {b_s[DW-1], b_s};
    dif_s  = {a_s[DW-1], a_s} - {b_s[DW-1], b_s};
    inc_s  = {a_s[DW-1], a_s} + (DW+1)'(1);
    dec_s  = {a_s[DW-1], a_s} - (DW+1)'(1);
    lt     = a_s < b_s;
    gt     = a_s > b_s;
    eq     = a_s == b_s;
    ma     = a_s[DW-1] ? DW'(0) - a_s : a_s;
    mb     = b_s[DW-1] ? DW'(0) - b_s : b_s;
    fi_top = a_s[DW-1 -: FB+1];

    simple.st  = fxalu_pkg::ST_OK;
    simple.val = '0;
    init_s.cmp = 1'b0;
    case (cmd)
      fxalu_pkg::CMD_ADD: simple = clamp33(sum_s);
      fxalu_pkg::CMD_SUB: simple = clamp33(dif_s);
      fxalu_pkg::CMD_INC: simple = clamp33(inc_s);
      fxalu_pkg::CMD_DEC: simple = clamp33(dec_s);
      fxalu_pkg::CMD_LT:  init_s.cmp = lt;
      fxalu_pkg::CMD_GT:  init_s.cmp = gt;
      fxalu_pkg::CMD_LE:  init_s.cmp = ~gt;
      fxalu_pkg::CMD_GE:  init_s.cmp = ~lt;
      fxalu_pkg::CMD_EQ:  init_s.cmp = eq;
      fxalu_pkg::CMD_NE:  init_s.cmp = ~eq;
      fxalu_pkg::CMD_MIN: simple.val = lt ? a_s : b_s;
      fxalu_pkg::CMD_MAX: simple.val = gt ? a_s : b_s;
      fxalu_pkg::CMD_FROM_INT: begin
        if ((&fi_top) || ~(|fi_top)) begin
          simple.val = a_s << FB;
        end else begin
          simple.st  = fxalu_pkg::ST_SAT;
          simple.val = a_s[DW-1] ? fxalu_pkg::S_MIN : fxalu_pkg::S_MAX;
        end
      end
      fxalu_pkg::CMD_TO_INT: simple.val = a_s >>> FB;
      default: ;
    endcase

    init_s.cmd = cmd;
    init_s.neg = a_s[DW-1] ^ b_s[DW-1];
    init_s.bz  = (b_s == '0);
    init_s.val = simple.val;
    init_s.st  = simple.st;
    init_s.num = (cmd == fxalu_pkg::CMD_MUL) ? NW'(ma) : {ma, {FB{1'b0}}};
    init_s.dvs = mb;
    init_s.rem = '0;
    init_s.quo = '0;
  end

  // -------------------------------------------------------------------------
  // Divider stages
  // -------------------------------------------------------------------------
  fxalu_pkg::div_t div_q [DS+1];
  fxalu_pkg::div_t div_d [1:DS];

  for (genvar k = 1; k <= DS; k++) begin : g_div
    assign div_d[k] = div_stage(div_q[k-1], k - 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0] <= init_s;
      for (int k = 1; k <= DS; k++) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Product / rounding-bit stage
  // -------------------------------------------------------------------------
  fxalu_pkg::fin_t            p_d, p_q;
  logic [fxalu_pkg::PROD_W-1:0] prod;

  assign prod = div_q[DS].num[DW-1:0] * div_q[DS].dvs;

  always_comb begin
    p_d.cmd  = div_q[DS].cmd;
    p_d.neg  = div_q[DS].neg;
    p_d.bz   = div_q[DS].bz;
    p_d.val  = div_q[DS].val;
    p_d.cmp  = div_q[DS].cmp;
    p_d.st   = div_q[DS].st;
    p_d.wide = (div_q[DS].cmd == fxalu_pkg::CMD_MUL) ? prod
                                                      : fxalu_pkg::PROD_W'(div_q[DS].quo);
    p_d.rup  = {div_q[DS].rem, 1'b0} >= {1'b0, div_q[DS].dvs};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q <= p_d;
    end
  end

  // -------------------------------------------------------------------------
  // Final rounding, saturation and result select
  // -------------------------------------------------------------------------
  logic [fxalu_pkg::PROD_W-1:0]     mag;
  fxalu_pkg::res_t                  rnd;
  logic [fxalu_pkg::M_FIELDS_W-1:0] fin;

  always_comb begin
    if (p_q.cmd == fxalu_pkg::CMD_MUL) begin
      mag = (p_q.wide + fxalu_pkg::HALF) >> FB;
    end else begin
      mag = p_q.wide + fxalu_pkg::PROD_W'(p_q.rup);
    end
    rnd = sat_mag(p_q.neg, mag);
    case (p_q.cmd)
      fxalu_pkg::CMD_MUL: fin = {rnd.st, 1'b0, rnd.val};
      fxalu_pkg::CMD_DIV: begin
        if (p_q.bz) begin
          fin = {fxalu_pkg::ST_DIV0, 1'b0, DW'(0)};
        end else begin
          fin = {rnd.st, 1'b0, rnd.val};
        end
      end
      default: fin = {p_q.st, p_q.cmp, p_q.val};
    endcase
  end

  // -------------------------------------------------------------------------
  // Valid tracking, output and skid registers
  // -------------------------------------------------------------------------
  logic                             deliver;
  logic                             out_load;
  logic [fxalu_pkg::M_FIELDS_W-1:0] out_q;
  logic [fxalu_pkg::M_FIELDS_W-1:0] skid_q;

  assign deliver  = adv & p_v_q;
  assign out_load = ~out_v_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      p_v_q    <= 1'b0;
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[DS-1:0], s_axis_tvalid};
        p_v_q <= vld_q[DS];
      end
      if (out_load) begin
        out_v_q  <= skid_v_q | deliver;
        skid_v_q <= 1'b0;
      end else begin
        skid_v_q <= skid_v_q | deliver;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= skid_v_q ? skid_q : fin;
    end else if (deliver) begin
      skid_q <= fin;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = fxalu_pkg::M_TDATA_W'(out_q);

endmodule

@@ hdl/fxalu_chk.sv @@
// ----------------------------------------------------------------------------
// fxalu_chk
// Port-level checks for the Q24.8 ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fxalu_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [fxalu_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic [fxalu_pkg::DATA_W-1:0] value;
  logic                         cmp;
  logic [fxalu_pkg::ST_W-1:0]   st;

  assign value = m_axis_tdata[fxalu_pkg::DATA_W-1:0];
  assign cmp   = m_axis_tdata[fxalu_pkg::M_CMP_BIT];
  assign st    = m_axis_tdata[fxalu_pkg::M_ST_LSB +: fxalu_pkg::ST_W];

  // stalled transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // input only backs up once a result is waiting
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending output");

  a_cmp_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && cmp |-> value == '0 && st == fxalu_pkg::ST_OK)
    else $error("compare result with nonzero value or status");

  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == fxalu_pkg::ST_DIV0 |-> value == '0 && !cmp)
    else $error("divide-by-zero result not cleared");

endmodule

bind fixed_point_q24_8_alu fxalu_chk u_fxalu_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
